[rtl/uboff_pkg.sv]
// Shared types, constants and layout tables for the uniform block offset packer.
package uboff_pkg;

    localparam int TYPE_W  = 5;
    localparam int COUNT_W = 8;
    localparam int FIELD_W = 16;
    localparam int MASK_W  = 4;
    localparam int SIZE_W  = 7;
    localparam int PROD_W  = SIZE_W + COUNT_W;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    localparam logic [TYPE_W-1:0] NUM_TYPES  = 5'd30;
    localparam logic [TYPE_W-1:0] MAT2_HALF  = 5'd24;
    localparam logic [TYPE_W-1:0] MAT2_FLOAT = 5'd27;

    localparam logic [MASK_W-1:0] STD140_ARRAY_MASK = 4'hF;
    localparam logic [SIZE_W-1:0] MAT2_STD140_SIZE  = 7'd32;
    localparam logic [SIZE_W-1:0] ELEM_MIN_SIZE     = 7'd16;
    localparam logic [MASK_W-1:0] FLIP_MASK         = 4'h7;
    localparam logic [MASK_W-1:0] FLIP_PAD          = 4'd8;

    localparam logic [FIELD_W-1:0] PUSH_LIMIT_RESET = 16'd128;

    function automatic logic [MASK_W-1:0] align_mask430(input logic [TYPE_W-1:0] t);
        logic [MASK_W-1:0] m;
        unique case (t)
            5'd0, 5'd4:                                   m = 4'h1;
            5'd1, 5'd5, 5'd8, 5'd12, 5'd16, 5'd20:        m = 4'h3;
            5'd2, 5'd3, 5'd6, 5'd7, 5'd9, 5'd13, 5'd17,
            5'd21, 5'd24, 5'd27:                          m = 4'h7;
            5'd10, 5'd11, 5'd14, 5'd15, 5'd18, 5'd19,
            5'd22, 5'd23, 5'd25, 5'd26, 5'd28, 5'd29:     m = 4'hF;
            default:                                      m = 4'h0;
        endcase
        return m;
    endfunction

    function automatic logic [SIZE_W-1:0] size430(input logic [TYPE_W-1:0] t);
        logic [SIZE_W-1:0] s;
        unique case (t)
            5'd0, 5'd4:                                   s = 7'd2;
            5'd1, 5'd5, 5'd8, 5'd12, 5'd16, 5'd20:        s = 7'd4;
            5'd2, 5'd6:                                   s = 7'd6;
            5'd3, 5'd7, 5'd9, 5'd13, 5'd17, 5'd21:        s = 7'd8;
            5'd10, 5'd14, 5'd18, 5'd22:                   s = 7'd12;
            5'd11, 5'd15, 5'd19, 5'd23, 5'd24, 5'd27:     s = 7'd16;
            5'd25, 5'd28:                                 s = 7'd48;
            5'd26, 5'd29:                                 s = 7'd64;
            default:                                      s = 7'd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/uboff_place.sv]
// Placement of one uniform in one layout: align the running end, then add the footprint.
module uboff_place
    import uboff_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic [OFFSET_BITS-1:0] end_in,
    input  logic [MASK_W-1:0]      align_mask,
    input  logic [SIZE_W-1:0]      step_bytes,
    input  logic [COUNT_W-1:0]     count,
    output logic [OFFSET_BITS-1:0] offset,
    output logic [OFFSET_BITS-1:0] end_out,
    output logic                   sat
);

    localparam int EXT_W = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;

    logic [EXT_W-1:0]  omax;
    logic [EXT_W-1:0]  mask_ext;
    logic [EXT_W-1:0]  aligned;
    logic              off_sat;
    logic [COUNT_W-1:0] mult_count;
    logic [PROD_W-1:0] footprint;
    logic [EXT_W-1:0]  end_sum;
    logic              end_sat;

    assign omax     = EXT_W'({OFFSET_BITS{1'b1}});
    assign mask_ext = EXT_W'(align_mask);
    assign aligned  = (EXT_W'(end_in) + mask_ext) & ~mask_ext;
    assign off_sat  = aligned > omax;
    assign offset   = off_sat ? {OFFSET_BITS{1'b1}} : aligned[OFFSET_BITS-1:0];

    assign mult_count = (count == '0) ? COUNT_W'(1) : count;
    assign footprint  = PROD_W'(step_bytes) * PROD_W'(mult_count);
    assign end_sum    = EXT_W'(offset) + EXT_W'(footprint);
    assign end_sat    = end_sum > omax;
    assign end_out    = end_sat ? {OFFSET_BITS{1'b1}} : end_sum[OFFSET_BITS-1:0];

    assign sat = off_sat | end_sat;

endmodule

[rtl/uniform_block_offset_packer.sv]
// Top level of the uniform block offset packer.
// Each input transfer places one uniform under std140 and std430, and its result passes
// through the input register and then the output register. A new transfer is taken every
// cycle while the output is not held by back-pressure, with the whole
// placement (table lookup, align, one small multiply, saturating add) done between the
// input register and the output register, and the running end offsets updated as the
// result is registered. The output register holds a finished result under back-pressure
// while the input register takes the next item. Invalid type codes return bad_type and
// leave the running offsets untouched. Write push_limit_bytes only while idle.
module uniform_block_offset_packer
    import uboff_pkg::*;
#(
    parameter int OFFSET_BITS = 16,
    parameter int MAX_ARRAY   = 255
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [FIELD_W-1:0]   cfg_wr_data,    // push_limit_bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,        // type_code[4:0], array_count[12:5]
    input  logic                 s_tuser,        // first_of_block
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,        // offset_std140[15:0], offset_std430[31:16],
                                                 // use_push_constants[32], flip_offset[48:33]
    output logic [M_TUSER_W-1:0] m_tuser         // bad_type[0], overflow[1]
);

    localparam int EXT_W  = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;
    localparam int WIDE_W = EXT_W - 1;

    logic                   in_valid_reg;
    logic [TYPE_W-1:0]      in_type_reg;
    logic [COUNT_W-1:0]     in_count_reg;
    logic                   in_first_reg;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_tdata_reg;
    logic [M_TUSER_W-1:0]   out_tuser_reg;
    logic [OFFSET_BITS-1:0] end140_reg;
    logic [OFFSET_BITS-1:0] end430_reg;
    logic [FIELD_W-1:0]     push_limit_reg;

    logic                   advance;
    logic                   bad;
    logic                   is_mat2;
    logic                   is_array;
    logic [COUNT_W-1:0]     count_eff;
    logic [MASK_W-1:0]      mask430;
    logic [MASK_W-1:0]      mask140;
    logic [SIZE_W-1:0]      sz430;
    logic [SIZE_W-1:0]      sz140;
    logic [SIZE_W-1:0]      step430;
    logic [SIZE_W-1:0]      step140;
    logic [OFFSET_BITS-1:0] base140;
    logic [OFFSET_BITS-1:0] base430;
    logic [OFFSET_BITS-1:0] off140;
    logic [OFFSET_BITS-1:0] off430;
    logic [OFFSET_BITS-1:0] new140;
    logic [OFFSET_BITS-1:0] new430;
    logic                   sat140;
    logic                   sat430;
    logic                   push;
    logic [OFFSET_BITS-1:0] chosen;
    logic [EXT_W-1:0]       flip_sum;
    logic [OFFSET_BITS-1:0] flip;
    logic [WIDE_W-1:0]      off140_w;
    logic [WIDE_W-1:0]      off430_w;
    logic [WIDE_W-1:0]      flip_w;
    logic [M_TDATA_W-1:0]   out_tdata_next;
    logic [M_TUSER_W-1:0]   out_tuser_next;
    logic [OFFSET_BITS-1:0] end140_next;
    logic [OFFSET_BITS-1:0] end430_next;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    assign bad       = in_type_reg >= NUM_TYPES;
    assign is_mat2   = (in_type_reg == MAT2_HALF) || (in_type_reg == MAT2_FLOAT);
    assign count_eff = (int'(in_count_reg) > MAX_ARRAY) ? COUNT_W'(MAX_ARRAY) : in_count_reg;
    assign is_array  = count_eff != '0;

    assign mask430 = align_mask430(in_type_reg);
    assign sz430   = size430(in_type_reg);
    assign mask140 = (is_array | is_mat2) ? STD140_ARRAY_MASK : mask430;
    assign sz140   = is_mat2 ? MAT2_STD140_SIZE : sz430;
    assign step430 = (is_array && sz430 < ELEM_MIN_SIZE) ? ELEM_MIN_SIZE : sz430;
    assign step140 = (is_array && sz140 < ELEM_MIN_SIZE) ? ELEM_MIN_SIZE : sz140;

    assign base140 = in_first_reg ? '0 : end140_reg;
    assign base430 = in_first_reg ? '0 : end430_reg;

    uboff_place #(.OFFSET_BITS(OFFSET_BITS)) u_place140 (
        .end_in     (base140),
        .align_mask (mask140),
        .step_bytes (step140),
        .count      (count_eff),
        .offset     (off140),
        .end_out    (new140),
        .sat        (sat140)
    );

    uboff_place #(.OFFSET_BITS(OFFSET_BITS)) u_place430 (
        .end_in     (base430),
        .align_mask (mask430),
        .step_bytes (step430),
        .count      (count_eff),
        .offset     (off430),
        .end_out    (new430),
        .sat        (sat430)
    );

    assign push = (new430 != '0) &&
                  ((EXT_W'(new430) + EXT_W'(FLIP_PAD)) <= EXT_W'(push_limit_reg));
    assign chosen   = push ? new430 : new140;
    assign flip_sum = (EXT_W'(chosen) + EXT_W'(FLIP_MASK)) & ~EXT_W'(FLIP_MASK);
    assign flip     = (flip_sum > EXT_W'({OFFSET_BITS{1'b1}})) ?
                      {OFFSET_BITS{1'b1}} : flip_sum[OFFSET_BITS-1:0];

    assign off140_w = WIDE_W'(off140);
    assign off430_w = WIDE_W'(off430);
    assign flip_w   = WIDE_W'(flip);

    always_comb begin
        if (bad) begin
            out_tdata_next = '0;
            out_tuser_next = M_TUSER_W'(1);
            end140_next    = end140_reg;
            end430_next    = end430_reg;
        end else begin
            out_tdata_next = {7'd0, flip_w[FIELD_W-1:0], push,
                              off430_w[FIELD_W-1:0], off140_w[FIELD_W-1:0]};
            out_tuser_next = {sat140 | sat430, 1'b0};
            end140_next    = new140;
            end430_next    = new430;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            end140_reg     <= '0;
            end430_reg     <= '0;
            push_limit_reg <= PUSH_LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                push_limit_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                end140_reg    <= end140_next;
                end430_reg    <= end430_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg  <= s_tdata[TYPE_W-1:0];
            in_count_reg <= s_tdata[TYPE_W+COUNT_W-1:TYPE_W];
            in_first_reg <= s_tuser;
        end
        if (advance) begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= out_tuser_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the uniform block offset packer: table-driven and random uniforms.
`timescale 1ns / 1ps

module tb_top
    import uboff_pkg::*;
();

    typedef enum logic [TYPE_W-1:0] {
        UT_SHORT1, UT_SHORT2, UT_SHORT3, UT_SHORT4,
        UT_USHORT1, UT_USHORT2, UT_USHORT3, UT_USHORT4,
        UT_INT1, UT_INT2, UT_INT3, UT_INT4,
        UT_UINT1, UT_UINT2, UT_UINT3, UT_UINT4,
        UT_HALF1, UT_HALF2, UT_HALF3, UT_HALF4,
        UT_FLOAT1, UT_FLOAT2, UT_FLOAT3, UT_FLOAT4,
        UT_HALF2X2, UT_HALF3X3, UT_HALF4X4,
        UT_FLOAT2X2, UT_FLOAT3X3, UT_FLOAT4X4,
        UT_INVALID30, UT_INVALID31
    } utype_t;

    typedef struct packed {
        logic [FIELD_W-1:0] o140;
        logic [FIELD_W-1:0] o430;
        logic               push;
        logic [FIELD_W-1:0] flip;
        logic               bad;
        logic               ovf;
    } placement_t;

    typedef struct packed {
        logic       typed;
        placement_t res;
    } item_tag_t;

    typedef struct packed {
        utype_t             t;
        logic [COUNT_W-1:0] cnt;
        logic               first;
        logic               typed;
        logic [FIELD_W-1:0] o140;
        logic [FIELD_W-1:0] o430;
        logic               push;
        logic [FIELD_W-1:0] flip;
        logic               bad;
        logic               ovf;
    } uniform_row_t;

    localparam int unsigned OFF_MAX      = 32'h0000_FFFF;
    localparam int          PHASE_ITEMS  = 238;
    localparam int          HOLD_CYCLES  = 300;

    localparam logic [MASK_W-1:0] ALIGN430 [0:29] = '{
        4'h1, 4'h3, 4'h7, 4'h7,  4'h1, 4'h3, 4'h7, 4'h7,
        4'h3, 4'h7, 4'hF, 4'hF,  4'h3, 4'h7, 4'hF, 4'hF,
        4'h3, 4'h7, 4'hF, 4'hF,  4'h3, 4'h7, 4'hF, 4'hF,
        4'h7, 4'hF, 4'hF,        4'h7, 4'hF, 4'hF
    };
    localparam logic [SIZE_W-1:0] SIZE430 [0:29] = '{
        7'd2, 7'd4, 7'd6, 7'd8,      7'd2, 7'd4, 7'd6, 7'd8,
        7'd4, 7'd8, 7'd12, 7'd16,    7'd4, 7'd8, 7'd12, 7'd16,
        7'd4, 7'd8, 7'd12, 7'd16,    7'd4, 7'd8, 7'd12, 7'd16,
        7'd16, 7'd48, 7'd64,         7'd16, 7'd48, 7'd64
    };

    uniform_row_t uniform_tab [0:24] = '{
        '{UT_FLOAT1,    8'd0,   1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 16'd8, 1'b0, 1'b0},
        '{UT_SHORT1,    8'd0,   1'b0, 1'b1, 16'd4, 16'd4, 1'b1, 16'd8, 1'b0, 1'b0},
        '{UT_INVALID30, 8'd0,   1'b0, 1'b1, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0},
        '{UT_INVALID31, 8'd255, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0},
        '{UT_USHORT3,   8'd0,   1'b0, 1'b1, 16'd8, 16'd8, 1'b1, 16'd16, 1'b0, 1'b0},
        '{UT_FLOAT2X2,  8'd0,   1'b0, 1'b1, 16'd16, 16'd16, 1'b1, 16'd32, 1'b0, 1'b0},
        '{UT_HALF2X2,   8'd1,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT4X4,  8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_SHORT1,    8'd255, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 16'd4080, 1'b0, 1'b0},
        '{UT_FLOAT4X4,  8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT4X4,  8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT4X4,  8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT4X4,  8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT4X4,  8'd255, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b1},
        '{UT_INVALID30, 8'd3,   1'b0, 1'b1, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0},
        '{UT_HALF1,     8'd0,   1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 16'd8, 1'b0, 1'b0},
        '{UT_HALF4,     8'd3,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_UINT3,     8'd0,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_HALF3X3,   8'd0,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT3X3,  8'd2,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_INT4,      8'd0,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_SHORT4,    8'd1,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_UINT2,     8'd0,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_FLOAT3,    8'd170, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{UT_HALF4X4,   8'd0,   1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [FIELD_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // type_code[4:0], array_count[12:5]
    logic                 s_tuser;    // first_of_block
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // offset_std140, offset_std430, use_push_constants,
                                      // flip_offset
    logic [M_TUSER_W-1:0] m_tuser;    // bad_type, overflow

    int unsigned    blk_end [0:1];
    int unsigned    push_lim;
    item_tag_t      tag_q [$];
    placement_t     placement_q [$];
    bit             failed;
    int             src_idle_pct;
    int             snk_idle_pct;
    int             hold_left;

    uniform_block_offset_packer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic placement_t place_uniform(input logic [TYPE_W-1:0] t,
                                                 input logic [COUNT_W-1:0] cnt,
                                                 input logic first);
        placement_t  r;
        int unsigned mask;
        int unsigned size;
        int unsigned elem;
        int unsigned off;
        int unsigned fin;
        int unsigned chosen;
        int unsigned fmask;
        logic        mat2;
        r = '0;
        if (t >= NUM_TYPES) begin
            r.bad = 1'b1;
            return r;
        end
        if (first) begin
            blk_end[0] = 0;
            blk_end[1] = 0;
        end
        mat2 = (t == MAT2_HALF) || (t == MAT2_FLOAT);
        for (int l = 0; l < 2; l++) begin
            mask = 32'(ALIGN430[t]);
            size = 32'(SIZE430[t]);
            if (l == 0 && (cnt != 0 || mat2)) mask = 32'(STD140_ARRAY_MASK);
            if (l == 0 && mat2) size = 32'(MAT2_STD140_SIZE);
            off = (blk_end[l] + mask) & ~mask;
            if (off > OFF_MAX) begin
                off = OFF_MAX;
                r.ovf = 1'b1;
            end
            elem = (size > 32'(ELEM_MIN_SIZE)) ? size : 32'(ELEM_MIN_SIZE);
            fin = (cnt != 0) ? off + elem * 32'(cnt) : off + size;
            if (fin > OFF_MAX) begin
                fin = OFF_MAX;
                r.ovf = 1'b1;
            end
            blk_end[l] = fin;
            if (l == 0) r.o140 = off[FIELD_W-1:0];
            else r.o430 = off[FIELD_W-1:0];
        end
        r.push = (blk_end[1] != 0) && (blk_end[1] + 32'(FLIP_PAD) <= push_lim);
        chosen = r.push ? blk_end[1] : blk_end[0];
        fmask = 32'(FLIP_MASK);
        chosen = (chosen + fmask) & ~fmask;
        if (chosen > OFF_MAX) chosen = OFF_MAX;
        r.flip = chosen[FIELD_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        placement_t exp_r;
        item_tag_t  tag;
        if (aresetn) begin
            if (cfg_wr_en) push_lim = 32'(cfg_wr_data);
            if (m_tvalid && m_tready) begin
                if (placement_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    failed = 1'b1;
                end else begin
                    exp_r = placement_q.pop_front();
                    check_field("offset_std140", 32'(exp_r.o140), 32'(m_tdata[15:0]));
                    check_field("offset_std430", 32'(exp_r.o430), 32'(m_tdata[31:16]));
                    check_field("use_push_constants", 32'(exp_r.push), 32'(m_tdata[32]));
                    check_field("flip_offset", 32'(exp_r.flip), 32'(m_tdata[48:33]));
                    check_field("bad_type", 32'(exp_r.bad), 32'(m_tuser[0]));
                    check_field("overflow", 32'(exp_r.ovf), 32'(m_tuser[1]));
                end
            end
            if (s_tvalid && s_tready) begin
                tag = tag_q.pop_front();
                exp_r = place_uniform(s_tdata[4:0], s_tdata[12:5], s_tuser);
                if (tag.typed) exp_r = tag.res;
                placement_q.insert(placement_q.size(), exp_r);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_uniform(input logic [TYPE_W-1:0] t, input logic [COUNT_W-1:0] cnt,
                                input logic first, input logic typed, input placement_t res);
        item_tag_t tag;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = S_TDATA_W'($urandom());
            s_tuser  = 1'($urandom());
            @(negedge aclk);
        end
        s_tvalid  = 1'b1;
        s_tdata   = {3'b000, cnt, t};
        s_tuser   = first;
        tag.typed = typed;
        tag.res   = res;
        tag_q.insert(tag_q.size(), tag);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (placement_q.size() != 0 || tag_q.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_push_limit(input logic [FIELD_W-1:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        placement_t         res;
        logic [TYPE_W-1:0]  t;
        logic [COUNT_W-1:0] cnt;
        logic               first;
        logic               deep_blk;
        logic [FIELD_W-1:0] lim;
        int                 n;
        int                 len;
        int                 r;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        failed       = 1'b0;
        hold_left    = 0;
        src_idle_pct = 38;
        snk_idle_pct = 78;
        blk_end[0]   = 0;
        blk_end[1]   = 0;
        push_lim     = 32'(PUSH_LIMIT_RESET);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (uniform_tab[k]) begin
            res = {uniform_tab[k].o140, uniform_tab[k].o430, uniform_tab[k].push,
                   uniform_tab[k].flip, uniform_tab[k].bad, uniform_tab[k].ovf};
            send_uniform(uniform_tab[k].t, uniform_tab[k].cnt, uniform_tab[k].first,
                         uniform_tab[k].typed, res);
        end

        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: lim = 16'd0;
                1: lim = 16'hFFFF;
                2: lim = 16'd24;
                3: lim = FIELD_W'($urandom_range(8, 300));
                4: lim = PUSH_LIMIT_RESET;
                default: lim = FIELD_W'($urandom());
            endcase
            write_push_limit(lim);
            src_idle_pct = (p < 2) ? 38 : (p < 4) ? 78 : 0;
            snk_idle_pct = (p < 2) ? 78 : (p < 4) ? 38 : 0;
            if (p == 1) hold_left = HOLD_CYCLES;
            n = 0;
            while (n < PHASE_ITEMS) begin
                deep_blk = ($urandom_range(9) == 0);
                len = deep_blk ? $urandom_range(20, 40) : $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                    if ($urandom_range(15) == 0) t = TYPE_W'($urandom_range(NUM_TYPES, 31));
                    else t = TYPE_W'($urandom_range(NUM_TYPES - 1));
                    r = $urandom_range(99);
                    if (deep_blk)
                        cnt = COUNT_W'((r < 40) ? $urandom_range(65, 255) :
                                       (r < 70) ? 0 : $urandom_range(1, 16));
                    else
                        cnt = COUNT_W'((r < 55) ? 0 : (r < 90) ? $urandom_range(1, 4) :
                                       (r < 97) ? $urandom_range(5, 64) :
                                       $urandom_range(65, 255));
                    send_uniform(t, cnt, first, 1'b0, '0);
                    n++;
                    if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
                end
            end
        end

        drain_results();
        repeat (5) @(posedge aclk);
        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
